>>> hdl/ccrc_pkg.sv
// Shared constants, types and the single-step LFSR function of the CRC update core.
`default_nettype none

package ccrc_pkg;

	// Widest CRC register the core supports, and the fixed width of the data field.
	localparam int CRC_BITS    = 32;
	localparam int DATA_BITS   = 32;
	localparam int IDX_BITS    = $clog2(CRC_BITS);
	localparam int DIDX_BITS   = $clog2(DATA_BITS);
	localparam int CNT_BITS    = $clog2(CRC_BITS + 1);
	localparam int CFG_BITS    = 32;
	localparam int WFIELD_BITS = 6;
	localparam int RIDX_BITS   = 3;

	typedef logic [CRC_BITS-1:0] crc_word_t;
	typedef logic [DATA_BITS-1:0] data_word_t;
	typedef logic [CNT_BITS-1:0] bit_cnt_t;

	// One column per CRC register bit, and one column per data bit.
	typedef crc_word_t [CRC_BITS-1:0] crc_cols_t;
	typedef crc_word_t [DATA_BITS-1:0] data_cols_t;

	typedef enum logic [RIDX_BITS-1:0] {
		REG_POLYNOMIAL    = 3'd0,
		REG_CRC_WIDTH     = 3'd1,
		REG_DATA_WIDTH    = 3'd2,
		REG_REFLECT_BITS  = 3'd3,
		REG_INVERT_RESULT = 3'd4,
		REG_INITIAL_VALUE = 3'd5
	} reg_idx_t;

	localparam logic [CFG_BITS-1:0]    RST_POLYNOMIAL = 32'h0000_0005;
	localparam logic [WFIELD_BITS-1:0] RST_CRC_WIDTH  = 6'd5;
	localparam logic [WFIELD_BITS-1:0] RST_DATA_WIDTH = 6'd4;
	localparam logic [CFG_BITS-1:0]    RST_INIT_VALUE = 32'hFFFF_FFFF;
	localparam crc_word_t RST_CRC = RST_INIT_VALUE &
		((crc_word_t'(1) << RST_CRC_WIDTH) - crc_word_t'(1));

	// Effective configuration after clamping and masking.
	typedef struct packed {
		crc_word_t poly;
		crc_word_t init;
		crc_word_t mask;
		bit_cnt_t  width;
		bit_cnt_t  nbits;
		logic      reflect;
		logic      invert;
	} cfg_t;

	// One shift of the CRC register with a zero data bit.
	function automatic crc_word_t crc_advance(input crc_word_t v, input cfg_t c);
		bit_cnt_t  top_pos;
		logic      fb;
		crc_word_t r;
		top_pos = c.width - bit_cnt_t'(1);
		fb      = v[top_pos[IDX_BITS-1:0]];
		r       = v << 1;
		if (fb) begin
			r = r ^ c.poly;
		end
		return r & c.mask;
	endfunction

endpackage

`default_nettype wire

>>> hdl/ccrc_cfg_regs.sv
// Configuration registers of the CRC update core and their clamped, masked view.
`default_nettype none

module ccrc_cfg_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	input  logic                                cfg_ready,
	input  logic [ccrc_pkg::RIDX_BITS-1:0]      cfg_index,
	input  logic [ccrc_pkg::CFG_BITS-1:0]       cfg_data,
	output logic                                cfg_wr,
	output ccrc_pkg::cfg_t                      cfg
);

	logic [ccrc_pkg::CFG_BITS-1:0]    poly_q;
	logic [ccrc_pkg::WFIELD_BITS-1:0] crc_width_q;
	logic [ccrc_pkg::WFIELD_BITS-1:0] data_width_q;
	logic                             reflect_q;
	logic                             invert_q;
	logic [ccrc_pkg::CFG_BITS-1:0]    init_q;

	localparam logic [ccrc_pkg::WFIELD_BITS-1:0] WMIN = ccrc_pkg::WFIELD_BITS'(2);
	localparam logic [ccrc_pkg::WFIELD_BITS-1:0] WMAX =
		ccrc_pkg::WFIELD_BITS'(ccrc_pkg::CRC_BITS);

	logic [ccrc_pkg::WFIELD_BITS-1:0] width_c;
	logic [ccrc_pkg::WFIELD_BITS-1:0] nbits_c;
	ccrc_pkg::crc_word_t              mask_c;

	assign cfg_wr = cfg_valid & cfg_ready;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poly_q       <= ccrc_pkg::RST_POLYNOMIAL;
			crc_width_q  <= ccrc_pkg::RST_CRC_WIDTH;
			data_width_q <= ccrc_pkg::RST_DATA_WIDTH;
			reflect_q    <= 1'b0;
			invert_q     <= 1'b0;
			init_q       <= ccrc_pkg::RST_INIT_VALUE;
		end else if (cfg_wr) begin
			case (ccrc_pkg::reg_idx_t'(cfg_index))
				ccrc_pkg::REG_POLYNOMIAL: begin
					poly_q <= cfg_data;
				end
				ccrc_pkg::REG_CRC_WIDTH: begin
					crc_width_q <= cfg_data[ccrc_pkg::WFIELD_BITS-1:0];
				end
				ccrc_pkg::REG_DATA_WIDTH: begin
					data_width_q <= cfg_data[ccrc_pkg::WFIELD_BITS-1:0];
				end
				ccrc_pkg::REG_REFLECT_BITS: begin
					reflect_q <= cfg_data[0];
				end
				ccrc_pkg::REG_INVERT_RESULT: begin
					invert_q <= cfg_data[0];
				end
				ccrc_pkg::REG_INITIAL_VALUE: begin
					init_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	// Out-of-range widths are pulled into range.
	always @* begin
		if (crc_width_q < WMIN) begin
			width_c = WMIN;
		end else if (crc_width_q > WMAX) begin
			width_c = WMAX;
		end else begin
			width_c = crc_width_q;
		end
		if (data_width_q == '0) begin
			nbits_c = ccrc_pkg::WFIELD_BITS'(1);
		end else if (data_width_q > width_c) begin
			nbits_c = width_c;
		end else begin
			nbits_c = data_width_q;
		end
		for (int i = 0; i < ccrc_pkg::CRC_BITS; i++) begin
			mask_c[i] = (ccrc_pkg::WFIELD_BITS'(i) < width_c);
		end
	end

	assign cfg.poly    = poly_q[ccrc_pkg::CRC_BITS-1:0] & mask_c;
	assign cfg.init    = init_q[ccrc_pkg::CRC_BITS-1:0] & mask_c;
	assign cfg.mask    = mask_c;
	assign cfg.width   = ccrc_pkg::CNT_BITS'(width_c);
	assign cfg.nbits   = ccrc_pkg::CNT_BITS'(nbits_c);
	assign cfg.reflect = reflect_q;
	assign cfg.invert  = invert_q;

endmodule

`default_nettype wire

>>> hdl/ccrc_matrix_gen.sv
// Builds the state and data XOR matrices of the parallel CRC by sweeping the LFSR.
`default_nettype none

module ccrc_matrix_gen (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr,
	input  ccrc_pkg::cfg_t       cfg,
	output ccrc_pkg::crc_cols_t  smat,
	output ccrc_pkg::data_cols_t dmat,
	output logic                 busy
);

	logic                        restart_q;
	logic                        run_q;
	ccrc_pkg::bit_cnt_t          k_q;
	ccrc_pkg::crc_word_t         pvec_q;
	ccrc_pkg::crc_cols_t         smat_q;
	ccrc_pkg::data_cols_t        dmat_q;

	ccrc_pkg::bit_cnt_t          last_k;
	ccrc_pkg::bit_cnt_t          dpos;
	logic [ccrc_pkg::DIDX_BITS-1:0] dsel;

	// A data bit injected at step i reaches the end after the remaining shifts,
	// so its column is the polynomial advanced that many times.
	assign last_k = cfg.nbits - ccrc_pkg::bit_cnt_t'(1);
	assign dpos   = cfg.reflect ? (last_k - k_q) : k_q;
	assign dsel   = dpos[ccrc_pkg::DIDX_BITS-1:0];

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			restart_q <= 1'b1;
			run_q     <= 1'b0;
			k_q       <= '0;
		end else if (cfg_wr) begin
			restart_q <= 1'b1;
			run_q     <= 1'b0;
		end else if (restart_q) begin
			restart_q <= 1'b0;
			run_q     <= 1'b1;
			k_q       <= '0;
		end else if (run_q) begin
			if (k_q == last_k) begin
				run_q <= 1'b0;
			end else begin
				k_q <= k_q + ccrc_pkg::bit_cnt_t'(1);
			end
		end
	end

	always @(posedge clk) begin
		if (restart_q) begin
			for (int j = 0; j < ccrc_pkg::CRC_BITS; j++) begin
				smat_q[j] <= cfg.mask & (ccrc_pkg::crc_word_t'(1) << j);
			end
			dmat_q <= '0;
			pvec_q <= cfg.poly;
		end else if (run_q) begin
			for (int j = 0; j < ccrc_pkg::CRC_BITS; j++) begin
				smat_q[j] <= ccrc_pkg::crc_advance(smat_q[j], cfg);
			end
			dmat_q[dsel] <= pvec_q;
			pvec_q       <= ccrc_pkg::crc_advance(pvec_q, cfg);
		end
	end

	assign smat = smat_q;
	assign dmat = dmat_q;
	assign busy = restart_q | run_q;

endmodule

`default_nettype wire

>>> hdl/ccrc_datapath.sv
// Input register, XOR network and result register of the CRC update core.
`default_nettype none

module ccrc_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ccrc_pkg::cfg_t       cfg,
	input  ccrc_pkg::crc_cols_t  smat,
	input  ccrc_pkg::data_cols_t dmat,
	input  logic                 busy,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  ccrc_pkg::data_word_t data_word,
	input  logic                 start_req,
	output logic                 out_valid,
	input  logic                 out_stall,
	output ccrc_pkg::crc_word_t  crc_out
);

	logic                 valid_s1;
	ccrc_pkg::data_word_t data_s1;
	logic                 start_s1;
	logic                 valid_s2;
	ccrc_pkg::crc_word_t  out_s2;
	ccrc_pkg::crc_word_t  crc_q;

	logic                 s2_en;
	logic                 s1_adv;
	logic                 in_take;
	ccrc_pkg::crc_word_t  cur;
	ccrc_pkg::crc_word_t  crc_next;
	ccrc_pkg::crc_word_t  rev;
	ccrc_pkg::crc_word_t  refl;
	ccrc_pkg::crc_word_t  res;
	ccrc_pkg::bit_cnt_t   shamt;

	assign s2_en    = !valid_s2 || !out_stall;
	assign s1_adv   = valid_s1 && s2_en;
	assign in_stall = busy || (valid_s1 && !s2_en);
	assign in_take  = in_valid && !in_stall;

	assign cur = start_s1 ? cfg.init : crc_q;

	// Each next-state bit is the parity of the selected state and data columns.
	for (genvar b = 0; b < ccrc_pkg::CRC_BITS; b++) begin : g_bit
		ccrc_pkg::crc_word_t  srow;
		ccrc_pkg::data_word_t drow;
		for (genvar j = 0; j < ccrc_pkg::CRC_BITS; j++) begin : g_s
			assign srow[j] = smat[j][b];
		end
		for (genvar p = 0; p < ccrc_pkg::DATA_BITS; p++) begin : g_d
			assign drow[p] = dmat[p][b];
		end
		assign crc_next[b] = (^(srow & cur)) ^ (^(drow & data_s1));
	end

	for (genvar i = 0; i < ccrc_pkg::CRC_BITS; i++) begin : g_rev
		assign rev[i] = crc_next[ccrc_pkg::CRC_BITS-1-i];
	end

	assign shamt = ccrc_pkg::bit_cnt_t'(ccrc_pkg::CRC_BITS) - cfg.width;
	assign refl  = rev >> shamt;

	always @* begin
		res = cfg.reflect ? refl : crc_next;
		if (cfg.invert) begin
			res = ~res;
		end
		res = res & cfg.mask;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			crc_q    <= ccrc_pkg::RST_CRC;
		end else begin
			if (in_take) begin
				valid_s1 <= 1'b1;
			end else if (s1_adv) begin
				valid_s1 <= 1'b0;
			end
			if (s2_en) begin
				valid_s2 <= valid_s1;
			end
			if (s1_adv) begin
				crc_q <= crc_next;
			end
		end
	end

	always @(posedge clk) begin
		if (in_take) begin
			data_s1  <= data_word;
			start_s1 <= start_req;
		end
		if (s1_adv) begin
			out_s2 <= res;
		end
	end

	assign out_valid = valid_s2;
	assign crc_out   = out_s2;

endmodule

`default_nettype wire

>>> hdl/configurable_crc_update_core.sv
// Top level of the configurable CRC update core.
`default_nettype none

// Folds one data word per clock, while in_stall is low, into a running CRC of
// 2 to 32 bits with a programmable polynomial, data width, initial value, bit
// order and output inversion. A word goes through an input register, one pass
// of an XOR network and a result register, so a transfer on the input side may
// happen in every cycle. A result moves from the input register into the
// result register when the output side is free, and is then presented on
// crc_out with out_valid. The XOR network uses two coefficient matrices that
// are rebuilt after reset and after every configuration write: the rebuild
// runs the LFSR once per data bit of the clamped data width, and in_stall is
// held high during it. Configuration writes are always accepted (cfg_ready
// stays high); a write should only be issued when no word is in flight, and
// every configuration write restarts the rebuild. A word with start_req set
// reloads the initial value before it is folded in.
module configurable_crc_update_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [ccrc_pkg::DATA_BITS-1:0]      data_word,
	input  logic                                start_req,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [ccrc_pkg::CRC_BITS-1:0]       crc_out,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [ccrc_pkg::RIDX_BITS-1:0]      cfg_index,
	input  logic [ccrc_pkg::CFG_BITS-1:0]       cfg_data
);

	ccrc_pkg::cfg_t       cfg;
	logic                 cfg_wr;
	ccrc_pkg::crc_cols_t  smat;
	ccrc_pkg::data_cols_t dmat;
	logic                 busy;

	// The register file never pushes back on a configuration transfer.
	assign cfg_ready = 1'b1;

	ccrc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg_wr    (cfg_wr),
		.cfg       (cfg)
	);

	// Coefficient sweep: one LFSR shift of every column per cycle.
	ccrc_matrix_gen u_mat (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg_wr (cfg_wr),
		.cfg    (cfg),
		.smat   (smat),
		.dmat   (dmat),
		.busy   (busy)
	);

	// Word path: input register, XOR network, result register.
	ccrc_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.smat      (smat),
		.dmat      (dmat),
		.busy      (busy),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.data_word (data_word),
		.start_req (start_req),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.crc_out   (crc_out)
	);

endmodule

`default_nettype wire

>>> hdl/ccrc_checker.sv
// Port-level checks of the CRC update core and their attachment to the top level.
`default_nettype none

module ccrc_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic                           in_stall,
	input  logic                           out_valid,
	input  logic                           out_stall,
	input  logic [ccrc_pkg::CRC_BITS-1:0]  crc_out,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready
);

	// A held result keeps its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(crc_out))
		else $error("crc_out changed while stalled");

	// A configuration transfer always triggers a coefficient rebuild.
	a_cfg_rebuild: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |=> in_stall)
		else $error("input not stalled after configuration transfer");

	// Right after a word transfer, only a full and stalled output can stall the input.
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		$past(in_valid && !in_stall && !(cfg_valid && cfg_ready)) && in_stall
		|-> out_valid && out_stall)
		else $error("input stalled without output backpressure");

endmodule

bind configurable_crc_update_core ccrc_checker u_ccrc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.crc_out   (crc_out),
	.cfg_valid (cfg_valid),
	.cfg_ready (cfg_ready)
);

`default_nettype wire
